### hw/rtl/sfsi_pkg.sv
// shared constants and direction tables for the stroke font shape interpreter
// no dependencies
package sfsi_pkg;

    localparam int COORD_BITS_DEF = 17;  // default coordinate width in half pixels
    localparam int OUT_W          = 17;  // width of each coordinate on the result bus
    localparam int PROD_W         = 16;  // signed product of an offset and the scale
    localparam int OFF_W          = 18;  // signed offset in half pixels before wrapping

    // direction factor in half pixels per unit, encoded as a 3-bit signed value
    localparam logic [2:0] DIR_P2 = 3'b010;
    localparam logic [2:0] DIR_P1 = 3'b001;
    localparam logic [2:0] DIR_Z  = 3'b000;
    localparam logic [2:0] DIR_M1 = 3'b111;
    localparam logic [2:0] DIR_M2 = 3'b110;

    function automatic logic [2:0] dir_x2(input logic [3:0] code);
        logic [2:0] d;
        case (code)
            4'd0, 4'd1, 4'd2, 4'd14, 4'd15: d = DIR_P2;
            4'd3, 4'd13:                    d = DIR_P1;
            4'd4, 4'd12:                    d = DIR_Z;
            4'd5, 4'd11:                    d = DIR_M1;
            default:                        d = DIR_M2;
        endcase
        return d;
    endfunction

    function automatic logic [2:0] dir_y2(input logic [3:0] code);
        logic [2:0] d;
        case (code)
            4'd2, 4'd3, 4'd4, 4'd5, 4'd6:      d = DIR_P2;
            4'd1, 4'd7:                        d = DIR_P1;
            4'd0, 4'd8:                        d = DIR_Z;
            4'd9, 4'd15:                       d = DIR_M1;
            default:                           d = DIR_M2;
        endcase
        return d;
    endfunction

    // product times a direction factor, by shift and negate
    function automatic logic signed [OFF_W-1:0] dir_mul(input logic signed [PROD_W-1:0] p,
                                                        input logic [2:0] d);
        logic signed [OFF_W-1:0] ext;
        logic signed [OFF_W-1:0] r;
        ext = OFF_W'(p);
        case (d)
            DIR_P2:  r = ext <<< 1;
            DIR_P1:  r = ext;
            DIR_M1:  r = -ext;
            DIR_M2:  r = -(ext <<< 1);
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

### hw/rtl/sfsi_offset.sv
// offset unit: one scale multiply and the direction factors for a move
// depends on sfsi_pkg
module sfsi_offset import sfsi_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic [7:0]                    shape_byte,
    input  logic                          vec_sel,     // vector code, else a signed offset byte
    input  logic [6:0]                    scale,
    input  logic signed [PROD_W-1:0]      held_prod,   // dx product kept from the previous byte
    output logic signed [PROD_W-1:0]      prod,
    output logic signed [COORD_BITS-1:0]  dx,
    output logic signed [COORD_BITS-1:0]  dy
);

    logic signed [8:0]        op;
    logic signed [16:0]       prod_full;
    logic signed [OFF_W-1:0]  dx_w;
    logic signed [OFF_W-1:0]  dy_w;

    // length nibble or signed offset byte
    assign op = vec_sel ? $signed({5'b0, shape_byte[7:4]}) : 9'($signed(shape_byte));
    assign prod_full = op * $signed({1'b0, scale});
    assign prod = PROD_W'(prod_full);

    always_comb begin
        if (vec_sel) begin
            dx_w = dir_mul(prod, dir_x2(shape_byte[3:0]));
            dy_w = dir_mul(prod, dir_y2(shape_byte[3:0]));
        end else begin
            dx_w = OFF_W'(held_prod) <<< 1;
            dy_w = OFF_W'(prod) <<< 1;
        end
    end

    assign dx = COORD_BITS'(dx_w);
    assign dy = COORD_BITS'(dy_w);

endmodule

### hw/rtl/stroke_font_shape_interpreter.sv
// stroke font shape interpreter: an accepted shape byte reaches its result on the
// master side through the input register, then the result register
// throughput one shape byte per cycle; the only stall is a full result register
// that is not taken while the byte in the input register yields a segment
// synchronous active-low reset clears the pipeline, the parser and the pen position
// and loads the configuration defaults (scale 10, canvas height 400, hidden pen-up)
module stroke_font_shape_interpreter import sfsi_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // shape byte requests
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,     // [7:0] shape_byte
    input  logic [0:0]  s_tuser,     // [0] glyph_start
    // segment results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,     // x_from, y_from, x_to, y_to (17 bits each), zero pad
    output logic [3:0]  m_tuser,     // [1:0] pen_mode, [3:2] item_kind
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [11:0] cfg_data
);

    // register indexes
    localparam logic [1:0] CFG_SCALE  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_SHOW   = 2'd2;

    // pen modes
    localparam logic [1:0] PEN_DRAWN  = 2'd0;
    localparam logic [1:0] PEN_SHOWN  = 2'd1;
    localparam logic [1:0] PEN_HIDDEN = 2'd2;

    // item kinds
    localparam logic [1:0] KIND_SEG   = 2'd0;
    localparam logic [1:0] KIND_END   = 2'd1;
    localparam logic [1:0] KIND_MARK  = 2'd2;

    // control codes (high nibble zero)
    localparam logic [3:0] OP_END     = 4'd0;
    localparam logic [3:0] OP_PEN_DN  = 4'd1;
    localparam logic [3:0] OP_PEN_UP  = 4'd2;
    localparam logic [3:0] OP_ONE_OFF = 4'd8;
    localparam logic [3:0] OP_OFF_RUN = 4'd9;

    typedef enum logic [2:0] {
        PH_CMD,    // expecting a command byte
        PH_D8X,    // single offset, x byte
        PH_D8Y,    // single offset, y byte
        PH_D9X,    // offset run, x byte
        PH_D9Y,    // offset run, y byte
        PH_DONE    // glyph ended, waiting for glyph start
    } phase_t;

    // configuration
    logic [6:0]  scale_reg;
    logic [11:0] canvas_height_reg;
    logic        show_hidden_reg;

    // input register
    logic        a_valid_reg;
    logic [7:0]  a_byte_reg;
    logic        a_start_reg;

    // parser state
    phase_t                      phase_reg, phase_next;
    logic [1:0]                  pen_reg, pen_next;
    logic [COORD_BITS-1:0]       pos_x_reg, pos_x_next;
    logic [COORD_BITS-1:0]       pos_y_reg, pos_y_next;
    logic [7:0]                  held_dx_reg, held_dx_next;
    logic signed [PROD_W-1:0]    held_prod_reg, held_prod_next;

    // result register
    logic                        m_valid_reg;
    logic signed [OUT_W-1:0]     x_from_reg, y_from_reg, x_to_reg, y_to_reg;
    logic [1:0]                  pen_mode_reg, kind_reg;

    // working values for the byte in the input register
    phase_t                      cur_phase;
    logic [1:0]                  cur_pen;
    logic [COORD_BITS-1:0]       cur_px, cur_py, start_pos;
    logic [3:0]                  hi, lo;
    logic                        vec_sel;
    logic signed [PROD_W-1:0]    prod;
    logic signed [COORD_BITS-1:0] dx, dy;
    logic                        emit, do_move;
    logic [1:0]                  kind;
    logic                        adv;
    logic [COORD_BITS-1:0]       h2, y_from_flip, y_to_flip;

    assign cfg_ready = 1'b1;

    // a glyph start restarts the pen at (scale, scale) pixels, pen down
    assign start_pos = COORD_BITS'({scale_reg, 1'b0});
    assign cur_phase = a_start_reg ? PH_CMD : phase_reg;
    assign cur_pen   = a_start_reg ? PEN_DRAWN : pen_reg;
    assign cur_px    = a_start_reg ? start_pos : pos_x_reg;
    assign cur_py    = a_start_reg ? start_pos : pos_y_reg;
    assign hi        = a_byte_reg[7:4];
    assign lo        = a_byte_reg[3:0];
    assign vec_sel   = (cur_phase == PH_CMD);

    sfsi_offset #(
        .COORD_BITS (COORD_BITS)
    ) u_offset (
        .shape_byte (a_byte_reg),
        .vec_sel    (vec_sel),
        .scale      (scale_reg),
        .held_prod  (held_prod_reg),
        .prod       (prod),
        .dx         (dx),
        .dy         (dy)
    );

    // parser: next state and what the byte emits
    always_comb begin
        phase_next     = cur_phase;
        pen_next       = cur_pen;
        held_dx_next   = held_dx_reg;
        held_prod_next = held_prod_reg;
        emit           = 1'b0;
        do_move        = 1'b0;
        kind           = KIND_SEG;
        unique case (cur_phase)
            PH_D8X, PH_D9X: begin
                // keep the x byte and its scaled product for the y byte
                held_dx_next   = a_byte_reg;
                held_prod_next = prod;
                phase_next     = (cur_phase == PH_D8X) ? PH_D8Y : PH_D9Y;
            end
            PH_D8Y: begin
                phase_next = PH_CMD;
                emit       = 1'b1;
                do_move    = 1'b1;
                kind       = KIND_END;
            end
            PH_D9Y: begin
                if (held_dx_reg == 8'd0 && a_byte_reg == 8'd0) begin
                    // zero pair closes the run: marker only, no move
                    phase_next = PH_CMD;
                    emit       = 1'b1;
                    kind       = KIND_MARK;
                end else begin
                    phase_next = PH_D9X;
                    emit       = 1'b1;
                    do_move    = 1'b1;
                end
            end
            PH_CMD: begin
                if (hi != 4'd0) begin
                    // vector: direction from the low nibble, length from the high
                    emit    = 1'b1;
                    do_move = 1'b1;
                end else begin
                    case (lo)
                        OP_END:     phase_next = PH_DONE;
                        OP_PEN_DN:  pen_next   = PEN_DRAWN;
                        OP_PEN_UP:  pen_next   = show_hidden_reg ? PEN_SHOWN : PEN_HIDDEN;
                        OP_ONE_OFF: phase_next = PH_D8X;
                        OP_OFF_RUN: phase_next = PH_D9X;
                        default:    phase_next = PH_CMD;
                    endcase
                end
            end
            default: begin
                // glyph ended: bytes pass without effect
                phase_next = PH_DONE;
            end
        endcase
    end

    // coordinates wrap at the coordinate width
    assign pos_x_next = do_move ? cur_px + COORD_BITS'(dx) : cur_px;
    assign pos_y_next = do_move ? cur_py + COORD_BITS'(dy) : cur_py;

    // y flip against twice the canvas height, in half pixels
    assign h2          = COORD_BITS'({canvas_height_reg, 1'b0});
    assign y_from_flip = h2 - cur_py;
    assign y_to_flip   = h2 - pos_y_next;

    // the byte moves on unless it has a result and the result register is held
    assign adv      = a_valid_reg && (!emit || !m_valid_reg || m_tready);
    assign s_tready = !a_valid_reg || adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg         <= 7'd10;
            canvas_height_reg <= 12'd400;
            show_hidden_reg   <= 1'b0;
            a_valid_reg       <= 1'b0;
            phase_reg         <= PH_CMD;
            pen_reg           <= PEN_DRAWN;
            pos_x_reg         <= '0;
            pos_y_reg         <= '0;
            held_dx_reg       <= '0;
            held_prod_reg     <= '0;
            m_valid_reg       <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    CFG_SCALE:  scale_reg         <= cfg_data[6:0];
                    CFG_HEIGHT: canvas_height_reg <= cfg_data;
                    CFG_SHOW:   show_hidden_reg   <= cfg_data[0];
                    default:    ;
                endcase
            end

            if (s_tready) begin
                a_valid_reg <= s_tvalid;
            end

            if (adv) begin
                phase_reg     <= phase_next;
                pen_reg       <= pen_next;
                pos_x_reg     <= pos_x_next;
                pos_y_reg     <= pos_y_next;
                held_dx_reg   <= held_dx_next;
                held_prod_reg <= held_prod_next;
            end

            if (adv && emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            a_byte_reg  <= s_tdata;
            a_start_reg <= s_tuser[0];
        end
        if (adv && emit) begin
            x_from_reg   <= OUT_W'($signed(cur_px));
            y_from_reg   <= OUT_W'($signed(y_from_flip));
            x_to_reg     <= OUT_W'($signed(pos_x_next));
            y_to_reg     <= OUT_W'($signed(y_to_flip));
            pen_mode_reg <= cur_pen;
            kind_reg     <= kind;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0, y_to_reg, x_to_reg, y_from_reg, x_from_reg};
    assign m_tuser  = {kind_reg, pen_mode_reg};

`ifndef SYNTH
    // a marker reports the current position at both ends
    a_marker_still: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[3:2] == KIND_MARK |->
            m_tdata[16:0] == m_tdata[50:34] && m_tdata[33:17] == m_tdata[67:51])
        else $error("marker result with differing ends");

    // pen mode is never the unused code
    a_pen_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser[1:0] != 2'd3)
        else $error("unused pen mode code");

    // input side stalls only behind a held result
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without a held result");
`endif

endmodule

### verif/stroke_font_shape_interpreter_test.sv
// self-checking testbench for the stroke font shape interpreter: shape byte stream in,
// pen segments out, every result checked against a predictor kept inside this file
// depends on sfsi_pkg and the stroke_font_shape_interpreter rtl
`timescale 1ns / 100ps

module stroke_font_shape_interpreter_test;
    import sfsi_pkg::*;

    // register indexes of the configuration channel
    localparam logic [1:0] REG_SCALE  = 2'd0;
    localparam logic [1:0] REG_CANVAS = 2'd1;
    localparam logic [1:0] REG_SHOW   = 2'd2;

    // low-nibble control codes when the high nibble is zero
    localparam logic [3:0] CODE_END      = 4'd0;
    localparam logic [3:0] CODE_PEN_DOWN = 4'd1;
    localparam logic [3:0] CODE_PEN_UP   = 4'd2;
    localparam logic [3:0] CODE_PAIR     = 4'd8;
    localparam logic [3:0] CODE_PAIRS    = 4'd9;

    // pen_mode codes
    localparam logic [1:0] PEN_DRAWN  = 2'd0;
    localparam logic [1:0] PEN_SHOWN  = 2'd1;
    localparam logic [1:0] PEN_HIDDEN = 2'd2;

    // item_kind codes
    localparam logic [1:0] KIND_SEG     = 2'd0;
    localparam logic [1:0] KIND_SEG_END = 2'd1;
    localparam logic [1:0] KIND_MARKER  = 2'd2;

    // pipeline is two deep, so SETTLE_CYCLES covers bytes still in flight
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_BYTES   = 100;

    typedef enum logic [2:0] {
        PH_CMD, PH_PAIR_X, PH_PAIR_Y, PH_LIST_X, PH_LIST_Y, PH_DONE
    } parse_phase_t;

    // positions wrap at COORD_BITS_DEF, which equals the result field width
    typedef logic [COORD_BITS_DEF-1:0] coord_t;

    typedef struct packed {
        logic [OUT_W-1:0] x_from;
        logic [OUT_W-1:0] y_from;
        logic [OUT_W-1:0] x_to;
        logic [OUT_W-1:0] y_to;
        logic [1:0]       pen_mode;
        logic [1:0]       item_kind;
    } segment_t;

    typedef struct {
        logic [7:0] shape;
        logic       start;
    } shape_req_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;
    logic [0:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [71:0] m_tdata;
    logic [3:0]  m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [11:0] cfg_data  = '0;

    stroke_font_shape_interpreter DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        aclk = 1'b1;
        #1;
        aclk = 1'b0;
        #1;
    end

    // ---------------------------------------------------------------
    // predictor state: a private copy of the registers and the parser
    // ---------------------------------------------------------------
    logic [6:0]   cur_scale;
    logic [11:0]  cur_canvas;
    logic         cur_show;
    parse_phase_t phase_q;
    coord_t       pen_x;
    coord_t       pen_y;
    logic [7:0]   held_dx;
    logic [1:0]   pen_q;

    segment_t   seg_expect[$];   // segments predicted but not yet seen
    shape_req_t byte_queue[$];   // shape bytes waiting for the driver

    int  bytes_queued   = 0;
    int  bytes_accepted = 0;
    int  fault_count    = 0;
    int  tx_max         = 5;     // sender gap limit for the current stretch
    int  rx_max         = 5;     // receiver stall limit for the current stretch
    int  send_hold      = 0;
    int  rx_hold        = 0;
    bit  byte_taken     = 1'b0;  // handshake seen at the last rising edge
    bit  seg_taken      = 1'b0;

    // half-pixel direction components per unit length, indexed by the low nibble
    function automatic int heading_dx(input logic [3:0] code);
        case (code)
            4'd0, 4'd1, 4'd2, 4'd14, 4'd15:   return 2;
            4'd3, 4'd13:                      return 1;
            4'd4, 4'd12:                      return 0;
            4'd5, 4'd11:                      return -1;
            default:                          return -2;
        endcase
    endfunction

    function automatic int heading_dy(input logic [3:0] code);
        case (code)
            4'd2, 4'd3, 4'd4, 4'd5, 4'd6:     return 2;
            4'd1, 4'd7:                       return 1;
            4'd0, 4'd8:                       return 0;
            4'd9, 4'd15:                      return -1;
            default:                          return -2;
        endcase
    endfunction

    // y leaves the block flipped about the canvas height, in half pixels
    function automatic logic [OUT_W-1:0] flip_y(input coord_t y);
        return OUT_W'(2 * int'(cur_canvas) - int'(y));
    endfunction

    task automatic record_segment(input coord_t fx, input coord_t fy,
                                  input coord_t tx, input coord_t ty,
                                  input logic [1:0] kind);
        segment_t s;
        s.x_from    = fx;
        s.y_from    = flip_y(fy);
        s.x_to      = tx;
        s.y_to      = flip_y(ty);
        s.pen_mode  = pen_q;
        s.item_kind = kind;
        seg_expect.push_back(s);
    endtask

    task automatic move_pen(input int dx, input int dy, input logic [1:0] kind);
        coord_t fx;
        coord_t fy;
        fx    = pen_x;
        fy    = pen_y;
        pen_x = pen_x + coord_t'(dx);
        pen_y = pen_y + coord_t'(dy);
        record_segment(fx, fy, pen_x, pen_y, kind);
    endtask

    // one accepted shape byte through the parser
    task automatic interpret_byte(input logic [7:0] b, input logic start);
        logic [3:0] hi;
        logic [3:0] lo;
        int         sc;
        hi = b[7:4];
        lo = b[3:0];
        sc = int'(cur_scale);
        // glyph start puts the pen at (scale, scale) pixels and re-reads b as a command
        if (start) begin
            pen_x   = coord_t'(2 * sc);
            pen_y   = coord_t'(2 * sc);
            pen_q   = PEN_DRAWN;
            phase_q = PH_CMD;
        end
        case (phase_q)
            PH_PAIR_X: begin
                held_dx = b;
                phase_q = PH_PAIR_Y;
            end
            PH_PAIR_Y: begin
                phase_q = PH_CMD;
                move_pen(2 * int'($signed(held_dx)) * sc, 2 * int'($signed(b)) * sc,
                         KIND_SEG_END);
            end
            PH_LIST_X: begin
                held_dx = b;
                phase_q = PH_LIST_Y;
            end
            PH_LIST_Y: begin
                // a zero pair closes the list with a marker at the current position
                if (held_dx == 8'd0 && b == 8'd0) begin
                    phase_q = PH_CMD;
                    record_segment(pen_x, pen_y, pen_x, pen_y, KIND_MARKER);
                end else begin
                    phase_q = PH_LIST_X;
                    move_pen(2 * int'($signed(held_dx)) * sc, 2 * int'($signed(b)) * sc,
                             KIND_SEG);
                end
            end
            PH_CMD: begin
                if (hi != 4'd0) begin
                    // vectors draw whatever the pen state, it only sets pen_mode
                    move_pen(heading_dx(lo) * int'(hi) * sc, heading_dy(lo) * int'(hi) * sc,
                             KIND_SEG);
                end else begin
                    case (lo)
                        CODE_END:      phase_q = PH_DONE;
                        CODE_PEN_DOWN: pen_q = PEN_DRAWN;
                        CODE_PEN_UP:   pen_q = cur_show ? PEN_SHOWN : PEN_HIDDEN;
                        CODE_PAIR:     phase_q = PH_PAIR_X;
                        CODE_PAIRS:    phase_q = PH_LIST_X;
                        default: ;
                    endcase
                end
            end
            default: ;   // after the end code everything waits for a glyph start
        endcase
    endtask

    task automatic note_fault(input string msg);
        fault_count++;
        if (fault_count <= 10)
            $display("mismatch: %s", msg);
    endtask

    task automatic check_segment();
        segment_t got;
        segment_t want;
        got.x_from    = m_tdata[0*OUT_W +: OUT_W];
        got.y_from    = m_tdata[1*OUT_W +: OUT_W];
        got.x_to      = m_tdata[2*OUT_W +: OUT_W];
        got.y_to      = m_tdata[3*OUT_W +: OUT_W];
        got.pen_mode  = m_tuser[1:0];
        got.item_kind = m_tuser[3:2];
        if (seg_expect.size() == 0) begin
            note_fault($sformatf("segment with nothing expected: %0d,%0d -> %0d,%0d pen %0d kind %0d",
                       $signed(got.x_from), $signed(got.y_from), $signed(got.x_to),
                       $signed(got.y_to), got.pen_mode, got.item_kind));
        end else begin
            want = seg_expect.pop_front();
            if (got.x_from !== want.x_from || got.y_from !== want.y_from ||
                got.x_to !== want.x_to || got.y_to !== want.y_to ||
                got.pen_mode !== want.pen_mode || got.item_kind !== want.item_kind) begin
                note_fault($sformatf({"expected %0d,%0d -> %0d,%0d pen %0d kind %0d, ",
                                      "got %0d,%0d -> %0d,%0d pen %0d kind %0d"},
                           $signed(want.x_from), $signed(want.y_from), $signed(want.x_to),
                           $signed(want.y_to), want.pen_mode, want.item_kind,
                           $signed(got.x_from), $signed(got.y_from), $signed(got.x_to),
                           $signed(got.y_to), got.pen_mode, got.item_kind));
            end
        end
    endtask

    // ---------------------------------------------------------------
    // monitor: both handshakes sampled at the rising edge
    // ---------------------------------------------------------------
    always @(posedge aclk) begin
        byte_taken = 1'b0;
        seg_taken  = 1'b0;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                byte_taken = 1'b1;
                interpret_byte(s_tdata, s_tuser[0]);
                bytes_accepted++;
            end
            if (m_tvalid && m_tready) begin
                seg_taken = 1'b1;
                check_segment();
            end
        end
    end

    // ---------------------------------------------------------------
    // driver: one request at a time from byte_queue, random gap after each
    // ---------------------------------------------------------------
    always @(negedge aclk) begin
        shape_req_t req;
        if (!aresetn) begin
            s_tvalid  <= 1'b0;
            send_hold = 0;
        end else if (!s_tvalid || byte_taken) begin
            if (send_hold > 0) begin
                send_hold--;
                s_tvalid <= 1'b0;
            end else if (byte_queue.size() > 0) begin
                req = byte_queue.pop_front();
                s_tvalid   <= 1'b1;
                s_tdata    <= req.shape;
                s_tuser[0] <= req.start;
                send_hold  = $urandom_range(0, tx_max);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: after each taken segment, hold tready low for a random stall
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_hold  = 0;
        end else begin
            if (seg_taken)
                rx_hold = $urandom_range(0, rx_max);
            if (rx_hold > 0) begin
                m_tready <= 1'b0;
                rx_hold--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------
    task automatic push_byte(input logic [7:0] b, input logic start);
        shape_req_t req;
        req.shape = b;
        req.start = start;
        byte_queue.push_back(req);
        bytes_queued++;
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [11:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_SCALE:  cur_scale  = value[6:0];
            REG_CANVAS: cur_canvas = value[11:0];
            REG_SHOW:   cur_show   = value[0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // every request taken, every segment seen, then let the pipeline run dry
    task automatic wait_settled();
        while (bytes_accepted != bytes_queued || seg_expect.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [7:0] any_vector();
        return {4'($urandom_range(1, 15)), 4'($urandom_range(0, 15))};
    endfunction

    // a well-formed glyph with random content, sometimes broken or noisy
    task automatic random_glyph();
        int         n;
        int         r;
        int         k;
        logic [7:0] dx;
        logic [7:0] dy;
        logic [7:0] v;
        push_byte(($urandom_range(0, 9) < 7) ? any_vector() : 8'($urandom), 1'b1);
        n = $urandom_range(3, 14);
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 40) begin
                push_byte(any_vector(), 1'b0);
            end else if (r < 50) begin
                push_byte({4'd0, $urandom_range(0, 1) ? CODE_PEN_UP : CODE_PEN_DOWN}, 1'b0);
            end else if (r < 62) begin
                push_byte({4'd0, CODE_PAIR}, 1'b0);
                push_byte(8'($urandom), 1'b0);
                push_byte(8'($urandom), 1'b0);
            end else if (r < 77) begin
                push_byte({4'd0, CODE_PAIRS}, 1'b0);
                k = $urandom_range(0, 4);
                for (int j = 0; j < k; j++) begin
                    dx = ($urandom_range(0, 4) == 0) ? 8'd0 : 8'($urandom);
                    dy = 8'($urandom);
                    if (dx == 8'd0 && dy == 8'd0)
                        dy = 8'd1;
                    push_byte(dx, 1'b0);
                    push_byte(dy, 1'b0);
                end
                push_byte(8'd0, 1'b0);
                push_byte(8'd0, 1'b0);
            end else if (r < 82) begin
                // long straight run, enough at large scales to wrap the coordinates
                v = any_vector();
                k = $urandom_range(20, 45);
                for (int j = 0; j < k; j++)
                    push_byte(v, 1'b0);
            end else if (r < 88) begin
                // unused control codes are swallowed
                v = 8'($urandom_range(3, 15));
                if (v[3:0] == CODE_PAIR || v[3:0] == CODE_PAIRS)
                    v = 8'd3;
                push_byte(v, 1'b0);
            end else if (r < 92) begin
                // pair cut short: the next byte lands as the missing offset
                push_byte({4'd0, CODE_PAIR}, 1'b0);
                push_byte(8'($urandom), 1'b0);
            end else begin
                push_byte(8'($urandom), 1'b0);
            end
        end
        if ($urandom_range(0, 1)) begin
            push_byte({4'd0, CODE_END}, 1'b0);
            k = $urandom_range(0, 3);
            for (int j = 0; j < k; j++)
                push_byte(8'($urandom), 1'b0);
        end
        if ($urandom_range(0, 9) == 0) begin
            k = $urandom_range(2, 6);
            for (int j = 0; j < k; j++)
                push_byte(8'($urandom), ($urandom_range(0, 7) == 0));
        end
    endtask

    task automatic set_registers(input int sc, input int canvas, input int show);
        write_reg(REG_SCALE, 12'(sc));
        write_reg(REG_CANVAS, 12'(canvas));
        write_reg(REG_SHOW, 12'(show));
    endtask

    // ---------------------------------------------------------------
    // test sequence
    // ---------------------------------------------------------------
    initial begin
        int target;
        cur_scale  = 7'd10;
        cur_canvas = 12'd400;
        cur_show   = 1'b0;
        phase_q    = PH_CMD;
        pen_x      = '0;
        pen_y      = '0;
        held_dx    = '0;
        pen_q      = PEN_DRAWN;

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed part with the reset register values
        push_byte(8'h10, 1'b0);                  // vector before any glyph start, from 0,0
        push_byte(8'hF7, 1'b1);                  // glyph start, longest vector
        push_byte({4'd0, CODE_PEN_UP}, 1'b0);
        push_byte(8'h8C, 1'b0);                  // vector with pen up, hidden
        push_byte({4'd0, CODE_PAIRS}, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b0);                  // marker only, carrying the pen-up mode
        push_byte({4'd0, CODE_PEN_DOWN}, 1'b0);
        push_byte({4'd0, CODE_PAIR}, 1'b0);
        push_byte(8'h80, 1'b0);                  // most negative offset
        push_byte(8'h7F, 1'b0);                  // most positive offset
        push_byte({4'd0, CODE_PAIRS}, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h03, 1'b0);                  // zero dx alone does not end the list
        push_byte(8'hFB, 1'b0);
        push_byte(8'h05, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h03, 1'b0);                  // unused control code
        push_byte(8'h0F, 1'b0);                  // unused control code
        push_byte({4'd0, CODE_PAIR}, 1'b0);
        push_byte(8'h21, 1'b1);                  // glyph start cuts the pair short
        push_byte({4'd0, CODE_END}, 1'b0);
        push_byte(8'h44, 1'b0);                  // ignored after the end code
        push_byte(8'hFF, 1'b1);
        wait_settled();

        // random phases, each under its own register setting; all but one share the same idling limits
        for (int p = 0; p < 6; p++) begin
            case (p)
                0: set_registers(1, 0, 1);
                1: set_registers(64, 4095, 0);
                2: set_registers($urandom_range(1, 64), $urandom_range(0, 4095), 1);
                3: set_registers(64, 0, 1);
                4: set_registers(1, 4095, 0);
                default: set_registers($urandom_range(1, 64), $urandom_range(0, 4095),
                                       $urandom_range(0, 1));
            endcase
            // one phase runs flat out on both sides
            tx_max = (p == 2) ? 0 : 5;
            rx_max = (p == 2) ? 0 : 5;
            target = bytes_queued + PHASE_BYTES;
            while (bytes_queued < target)
                random_glyph();
            // sender holds off here until every segment has come back
            wait_settled();
        end

        if (seg_expect.size() != 0)
            note_fault($sformatf("%0d segments never arrived", seg_expect.size()));
        if (fault_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // hard stop well beyond the slowest legal run
    initial begin
        #400000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### stroke_font_shape_interpreter.f
hw/rtl/sfsi_pkg.sv
hw/rtl/sfsi_offset.sv
hw/rtl/stroke_font_shape_interpreter.sv
verif/stroke_font_shape_interpreter_test.sv
